// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the ray fill RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ORF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ORF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ORF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ORF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/orf_pkg.sv =====
// Types, board masks and the direction step function for the ray fill.
package orf_pkg;

    localparam int unsigned RAY_STEPS = 7;

    localparam logic [63:0] EAST_MASK = 64'hfefe_fefe_fefe_fefe;
    localparam logic [63:0] WEST_MASK = 64'h7f7f_7f7f_7f7f_7f7f;

    typedef enum logic [2:0] {
        DIR_N  = 3'd0,
        DIR_NE = 3'd1,
        DIR_E  = 3'd2,
        DIR_SE = 3'd3,
        DIR_S  = 3'd4,
        DIR_SW = 3'd5,
        DIR_W  = 3'd6,
        DIR_NW = 3'd7
    } dir_t;

    typedef enum logic {
        ACT_FLOOD   = 1'b0,
        ACT_BLOCKER = 1'b1
    } action_t;

    typedef struct packed {
        action_t     action;
        dir_t        direction;
        logic        capture_flag;
        logic [63:0] squares;
        logic [63:0] empty;
        logic        done;
    } ray_item_t;

    // One step along the ray, masked so that nothing wraps across a board edge
    function automatic logic [63:0] orf_step(input logic [63:0] s, input dir_t d);
        logic [63:0] r;
        unique case (d)
            DIR_N:   r = s << 8;
            DIR_NE:  r = (s << 9) & EAST_MASK;
            DIR_E:   r = (s << 1) & EAST_MASK;
            DIR_SE:  r = (s >> 7) & EAST_MASK;
            DIR_S:   r = s >> 8;
            DIR_SW:  r = (s >> 9) & WEST_MASK;
            DIR_W:   r = (s >> 1) & WEST_MASK;
            DIR_NW:  r = (s << 7) & WEST_MASK;
            default: r = s << 8;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/orf_cell.sv =====
// One ray step cell: applies a single flood or blocker step and registers it.
module orf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  orf_pkg::ray_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output orf_pkg::ray_item_t out_item,
    input  logic               out_ready
);
    import orf_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ray_item_t   item_reg;
    ray_item_t   item_next;
    logic [63:0] stepped;

    always_comb
    begin
        stepped   = orf_step(in_item.squares, in_item.direction);
        item_next = in_item;
        if (in_item.action == ACT_FLOOD)
        begin
            item_next.squares = in_item.squares | (stepped & in_item.empty);
        end
        else if (!in_item.done)
        begin
            // hold the first step that meets no empty square
            item_next.squares = stepped;
            item_next.done    = ((stepped & in_item.empty) == 64'd0);
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/orf_out.sv =====
// Output stage: forms the result set from the last cell and holds it for transfer.
module orf_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  orf_pkg::ray_item_t in_item,
    output logic               in_ready,
    output logic               out_valid,
    output logic [63:0]        result_squares,
    input  logic               out_stall
);
    import orf_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    always_comb
    begin
        if (in_item.action == ACT_BLOCKER)
        begin
            result_next = in_item.squares;
        end
        else if (in_item.capture_flag)
        begin
            result_next = orf_step(in_item.squares, in_item.direction);
        end
        else
        begin
            result_next = in_item.squares & in_item.empty;
        end
    end

    assign in_ready   = !valid_reg || !out_stall;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = valid_reg;
    assign result_squares = result_reg;

endmodule

// ===== rtl/core/occluded_ray_fill.sv =====
// Top level of the occluded ray fill: a chain of seven step cells and an output stage.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  input   | in        | in_valid / in_stall | action, direction, capture_flag,
//          |           |                     | start_squares, empty_squares
//  result  | out       | out_valid/out_stall | result_squares
//
// One item enters per cycle unless a stalled output has backed the chain up; its result passes seven
// step cells, one ray step each, then the output register that forms the result.
// Each stage carries its own valid bit, so a stalled output only stops the
// stages behind it once they are full; bubbles close up while the output waits.
// Reset clears the valid bits only; payload registers load on transfer.
`include "assert_macros.svh"

module occluded_ray_fill (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [2:0]  direction,
    input  logic        capture_flag,
    input  logic [63:0] start_squares,
    input  logic [63:0] empty_squares,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_squares
);
    import orf_pkg::*;

    // chain index k sits in front of cell k; index RAY_STEPS feeds the output stage
    ray_item_t chain_item  [0:RAY_STEPS];
    logic      chain_valid [0:RAY_STEPS];
    logic      chain_ready [0:RAY_STEPS];

    // pack the incoming transfer; the blocker search starts with nothing found
    always_comb
    begin
        chain_item[0].action       = action_t'(action);
        chain_item[0].direction    = dir_t'(direction);
        chain_item[0].capture_flag = capture_flag;
        chain_item[0].squares      = start_squares;
        chain_item[0].empty        = empty_squares;
        chain_item[0].done         = 1'b0;
    end

    assign chain_valid[0] = in_valid;
    assign in_stall       = !chain_ready[0];

    // one ray step per cell, handed forward every cycle unless the next stage is full and held
    for (genvar k = 0; k < RAY_STEPS; k++)
    begin : g_cell
        orf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .in_ready  (chain_ready[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    // capture step, empty mask or blocker set, then hold for transfer
    orf_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (chain_valid[RAY_STEPS]),
        .in_item        (chain_item[RAY_STEPS]),
        .in_ready       (chain_ready[RAY_STEPS]),
        .out_valid      (out_valid),
        .result_squares (result_squares),
        .out_stall      (out_stall)
    );

    // an accepted item is in the first cell on the next cycle
    `ORF_ASSERT_NEXT(a_first_cell_loads, clk, rst_n, in_valid && !in_stall, chain_valid[1])

    // the last cell holds its item while the output stage cannot take it
    `ORF_ASSERT_NEXT(a_last_cell_holds, clk, rst_n,
        chain_valid[RAY_STEPS] && !chain_ready[RAY_STEPS],
        chain_valid[RAY_STEPS] && $stable(chain_item[RAY_STEPS]))

    // a found blocker set never overlaps the empty squares
    `ORF_ASSERT_IMPL(a_blocker_clear, clk, rst_n,
        chain_valid[RAY_STEPS] && chain_item[RAY_STEPS].action == ACT_BLOCKER
            && chain_item[RAY_STEPS].done,
        (chain_item[RAY_STEPS].squares & chain_item[RAY_STEPS].empty) == 64'd0)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the occluded ray fill: random and directed rays against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orf_pkg::*;

    // Scoreboard: predict each accepted ray and hold the predictions in
    // transfer order until the matching result leaves the block.
    class ray_ledger;
        logic [63:0] expected_rays[$];
        int          mismatches = 0;

        // One step along the ray, with the file masks that stop edge wrap.
        function logic [63:0] step_once(logic [63:0] s, dir_t d);
            logic [63:0] r;
            case (d)
                DIR_N:   r = s << 8;
                DIR_NE:  r = (s << 9) & EAST_MASK;
                DIR_E:   r = (s << 1) & EAST_MASK;
                DIR_SE:  r = (s >> 7) & EAST_MASK;
                DIR_S:   r = s >> 8;
                DIR_SW:  r = (s >> 9) & WEST_MASK;
                DIR_W:   r = (s >> 1) & WEST_MASK;
                default: r = (s << 7) & WEST_MASK;
            endcase
            return r;
        endfunction

        function logic [63:0] flood_ray(logic [63:0] start, logic [63:0] empty, dir_t d,
                                        logic cap);
            logic [63:0] g;
            g = start;
            for (int i = 0; i < RAY_STEPS; i++)
                g |= step_once(g, d) & empty;
            return cap ? step_once(g, d) : (g & empty);
        endfunction

        function logic [63:0] first_blocker(logic [63:0] start, logic [63:0] empty, dir_t d);
            logic [63:0] g;
            g = start;
            for (int i = 0; i < RAY_STEPS; i++)
            begin
                g = step_once(g, d);
                if ((g & empty) == 64'd0)
                    return g;
            end
            return g;
        endfunction

        function void note_transfer(action_t a, dir_t d, logic cap, logic [63:0] start,
                                    logic [63:0] empty);
            if (a == ACT_FLOOD)
                expected_rays.push_back(flood_ray(start, empty, d, cap));
            else
                expected_rays.push_back(first_blocker(start, empty, d));
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (expected_rays.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_rays.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result_squares mismatch, expected %h, got %h",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_rays.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;     // tail of the run with no idling at all
    localparam int CYCLE_LIMIT  = 300000;  // far beyond the slowest correct run
    localparam int SETTLE       = 12;      // eight-stage pipe plus some margin

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic        action        = 1'b0;
    logic [2:0]  direction     = 3'd0;
    logic        capture_flag  = 1'b0;
    logic [63:0] start_squares = 64'd0;
    logic [63:0] empty_squares = 64'd0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [63:0] result_squares;

    // Receiver idling controls; the stimulus raises calm for the tail.
    logic        calm       = 1'b0;
    int          stall_left = 0;
    int          stall_pct  = 0;
    int          epoch      = 0;

    ray_ledger   ledger;

    occluded_ray_fill uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .direction      (direction),
        .capture_flag   (capture_flag),
        .start_squares  (start_squares),
        .empty_squares  (empty_squares),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_squares (result_squares)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels at the edge: every value read here is the one
    // that stood before the edge, since all drives land as nonblocking updates.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            ledger.note_transfer(action_t'(action), dir_t'(direction), capture_flag,
                                 start_squares, empty_squares);
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(result_squares);
    end

    // Receiver: stall in bursts of random length. Re-pick the burst rate at the start of
    // each epoch so that quiet stretches and heavy back-pressure both occur.
    always @(posedge clk)
    begin
        epoch <= epoch + 1;
        if (epoch % 256 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_pct <= 0;
                1:       stall_pct <= 10;
                default: stall_pct <= 40;
            endcase
        end
        if (calm)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: give up well past the slowest legal run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one ray and hold it until the block takes the transfer.
    // Call at a rising edge; returns at the edge of acceptance.
    task automatic send_ray(action_t a, dir_t d, logic cap, logic [63:0] s, logic [63:0] e);
        in_valid      <= 1'b1;
        action        <= a;
        direction     <= d;
        capture_flag  <= cap;
        start_squares <= s;
        empty_squares <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid for the requested idle time and scramble the idle payload, which must be ignored.
    task automatic idle_sender(int n);
        in_valid      <= 1'b0;
        action        <= 1'($urandom_range(0, 1));
        direction     <= 3'($urandom_range(0, 7));
        capture_flag  <= 1'($urandom_range(0, 1));
        start_squares <= rand64();
        empty_squares <= rand64();
        repeat (n) @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted ray has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] s;
        logic [63:0] e;
        int          gap_pct;
        int          shape;

        ledger  = new();
        gap_pct = 0;

        // Hold reset, then release it once and for all.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: every direction in both actions from a centre square (d4),
        // flood on an open board, blocker against a two-rank wall.
        for (int k = 0; k < 8; k++)
            send_ray(ACT_FLOOD, dir_t'(k), k[0], 64'h0000_0000_0800_0000, {64{1'b1}});
        for (int k = 0; k < 8; k++)
            send_ray(ACT_BLOCKER, dir_t'(k), k[1], 64'h0000_0000_0800_0000,
                     64'h00ff_ff00_00ff_ff00);
        // Occupied starting squares drop out of a flood without capture.
        send_ray(ACT_FLOOD, DIR_N, 1'b0, {64{1'b1}}, 64'd0);
        // Nothing to flood, capture on.
        send_ray(ACT_FLOOD, DIR_S, 1'b1, 64'd0, {64{1'b1}});
        // Capture reaches the occluding square on a4.
        send_ray(ACT_FLOOD, DIR_N, 1'b1, 64'h0000_0000_0000_0001, ~64'h0000_0000_0100_0000);
        // Full board, all empty: every blocker step meets an empty square,
        // so the seventh step comes back.
        send_ray(ACT_BLOCKER, DIR_N, 1'b0, {64{1'b1}}, {64{1'b1}});
        // Ray leaves the board at the east edge: the step is empty and returns zero.
        send_ray(ACT_BLOCKER, DIR_E, 1'b1, 64'h0000_0000_0000_0080, {64{1'b1}});
        // First step already misses the empty squares.
        send_ray(ACT_BLOCKER, DIR_NW, 1'b0, 64'h0000_0000_0000_0001, 64'd0);
        // Wrap masks on a full board both ways.
        send_ray(ACT_FLOOD, DIR_W, 1'b1, {64{1'b1}}, {64{1'b1}});
        send_ray(ACT_FLOOD, DIR_SE, 1'b0, 64'h8181_8181_8181_8181, {64{1'b1}});

        // Let the directed rays drain before the random part starts.
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            if (n == 400 || n == 800)
                wait_drained();
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 99) < gap_pct)
                idle_sender($urandom_range(1, 13));

            // Mostly board-like rays: one or two sliders on a part-filled
            // board. The rest is raw noise, extremes and starts on the board edge.
            shape = $urandom_range(0, 9);
            if (shape <= 5)
            begin
                s = 64'd1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    s |= 64'd1 << $urandom_range(0, 63);
                case ($urandom_range(0, 2))
                    0:       e = rand64() | rand64();
                    1:       e = rand64() & rand64();
                    default: e = rand64();
                endcase
                if ($urandom_range(0, 9) < 7)
                    e &= ~s;
            end
            else if (shape <= 7)
            begin
                s = rand64();
                e = rand64();
            end
            else if (shape == 8)
            begin
                case ($urandom_range(0, 2))
                    0:       s = 64'd0;
                    1:       s = {64{1'b1}};
                    default: s = rand64();
                endcase
                case ($urandom_range(0, 2))
                    0:       e = 64'd0;
                    1:       e = {64{1'b1}};
                    default: e = rand64();
                endcase
            end
            else
            begin
                s = rand64() & 64'hff81_8181_8181_81ff;
                e = rand64() | rand64();
            end

            send_ray(action_t'($urandom_range(0, 1)), dir_t'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), s, e);
        end

        // Wait out every outstanding ray, then a few more cycles for strays.
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
